@@ rtl/core/fict_pkg.sv @@
// Shared types and constants for the frequent item counter table.
package fict_pkg;

  localparam int SLOTS    = 16;
  localparam int KEY_BITS = 32;
  // Stored key width: the key field is 32 bits wide, so wider keys add nothing.
  localparam int KEY_W    = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = 32;
  localparam int FRAC_W   = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic MODE_OBSERVE = 1'b0;
  localparam logic MODE_REPORT  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] key;
  } in_t;

  typedef struct packed {
    logic [31:0] slot_key;
    logic [31:0] slot_count;
    logic        heavy;
    logic        last;
  } out_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic observe;    // apply one observed key this cycle
    logic rotate;     // shift every slot one place toward cell 0
    logic any_hit;    // some occupied slot matches the key
    logic any_empty;  // some slot is empty
  } cell_ctl_t;

endpackage

@@ rtl/core/fict_cell.sv @@
// One slot of the counter table: key, count and its links in the priority chains.
module fict_cell import fict_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic [KEY_W-1:0] obs_key,
  input  logic             hit_in,   // a lower slot already matched
  output logic             hit_out,
  input  logic             vac_in,   // a higher slot is empty
  output logic             vac_out,
  input  logic [KEY_W-1:0] nb_key,
  input  logic [CNT_W-1:0] nb_count,
  output logic [KEY_W-1:0] key_q,
  output logic [CNT_W-1:0] count_q
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             empty;
  logic             match;

  assign empty   = (count_r == '0);
  assign match   = !empty && (key_r == obs_key);
  assign hit_out = hit_in | match;
  assign vac_out = vac_in | empty;
  assign key_q   = key_r;
  assign count_q = count_r;

  always_comb begin
    key_nxt   = key_r;
    count_nxt = count_r;
    if (ctl.rotate) begin
      key_nxt   = nb_key;
      count_nxt = nb_count;
    end else if (ctl.observe) begin
      if (match && !hit_in) begin
        if (count_r != CNT_MAX) count_nxt = count_r + CNT_W'(1);
      end else if (!ctl.any_hit && ctl.any_empty) begin
        // take the key only in the highest empty slot
        if (empty && !vac_in) begin
          key_nxt   = obs_key;
          count_nxt = CNT_W'(1);
        end
      end else if (!ctl.any_hit && !ctl.any_empty) begin
        if (!empty) count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      count_r <= '0;
    end else begin
      key_r   <= key_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/core/frequent_item_counter_table_core.sv @@
// Top level: row of slot cells, item counter, threshold and report sequencer.
// Observe word: applied at the accepting edge, one per cycle, busy stays low.
// Report word: busy while the report runs; the slots rotate
// through the row once, one result per cycle from slot 0, the strobe registered
// from the report state. The receiver cannot stall.
// Synchronous active-low reset clears all slots, the item counter and the fraction.
module frequent_item_counter_table_core import fict_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_word,
  output logic              out_strobe,
  output out_t              out_word,
  input  logic              cfg_we,
  input  logic [FRAC_W-1:0] cfg_wdata
);

  typedef enum logic {ST_IDLE, ST_REPORT} state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  idx_r;
  logic [FRAC_W-1:0] frac_r;
  logic [CNT_W-1:0]  items_seen_r;
  logic [CNT_W-1:0]  low_r;
  logic              out_strobe_r;
  out_t              out_word_r;

  logic                  accept;
  logic [FRAC_W+CNT_W-1:0] prod;
  cell_ctl_t             ctl;
  logic [KEY_W-1:0]      obs_key;
  logic [SLOTS:0]        hit_c;
  logic [SLOTS:0]        vac_c;
  logic [KEY_W-1:0]      key_q   [SLOTS];
  logic [CNT_W-1:0]      count_q [SLOTS];

  assign busy    = (state_r == ST_REPORT);
  assign accept  = start && !busy;
  assign obs_key = in_word.key[KEY_W-1:0];
  assign prod    = frac_r * items_seen_r;

  assign hit_c[0]     = 1'b0;
  assign vac_c[SLOTS] = 1'b0;

  always_comb begin
    ctl.observe   = accept && (in_word.mode == MODE_OBSERVE);
    ctl.rotate    = (state_r == ST_REPORT);
    ctl.any_hit   = hit_c[SLOTS];
    ctl.any_empty = vac_c[0];
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    fict_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .obs_key  (obs_key),
      .hit_in   (hit_c[i]),
      .hit_out  (hit_c[i+1]),
      .vac_in   (vac_c[i+1]),
      .vac_out  (vac_c[i]),
      .nb_key   (key_q[(i + 1) % SLOTS]),
      .nb_count (count_q[(i + 1) % SLOTS]),
      .key_q    (key_q[i]),
      .count_q  (count_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      frac_r       <= '0;
      items_seen_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == ST_REPORT);
      if (cfg_we) frac_r <= cfg_wdata;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_word.mode == MODE_REPORT) begin
              state_r <= ST_REPORT;
              idx_r   <= '0;
            end else if (items_seen_r != CNT_MAX) begin
              items_seen_r <= items_seen_r + CNT_W'(1);
            end
          end
        end
        ST_REPORT: begin
          // emit the slot now in cell 0 while the row advances
          idx_r        <= idx_r + IDX_W'(1);
          if (idx_r == IDX_W'(SLOTS - 1)) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: threshold latched on every accepted word, results per slot.
  always_ff @(posedge clk) begin
    if (accept) low_r <= prod[FRAC_W+CNT_W-1:FRAC_W];
    if (state_r == ST_REPORT) begin
      out_word_r.slot_key   <= 32'(key_q[0]);
      out_word_r.slot_count <= count_q[0];
      out_word_r.heavy      <= (count_q[0] >= low_r);
      out_word_r.last       <= (idx_r == IDX_W'(SLOTS - 1));
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a report in progress");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.last) |=> !out_strobe)
    else $error("result strobe right after the last slot");

  a_items_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (items_seen_r >= $past(items_seen_r)))
    else $error("item counter went down");

  a_rows_hold_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ctl.observe)
    else $error("observe applied during a report");

endmodule

@@ test/frequent_item_counter_table_core_tb.sv @@
// Testbench for the frequent item counter table: directed slot cases, then random key streams.
module frequent_item_counter_table_core_tb;
  import fict_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] KEY_MASK =
    (KEY_W >= 32) ? 32'hFFFF_FFFF : ((32'h1 << KEY_W) - 32'h1);

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_t               in_word;
  logic              out_strobe;
  out_t              out_word;
  logic              cfg_we;
  logic [FRAC_W-1:0] cfg_wdata;

  frequent_item_counter_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Local copy of the table state
  logic [31:0]       table_key [SLOTS];
  logic [CNT_W-1:0]  table_count [SLOTS];
  logic [CNT_W-1:0]  seen_count;
  logic [FRAC_W-1:0] heavy_frac;

  out_t pending_slots[$];
  int   error_count;
  int   idle_pct;

  always #5 clk = ~clk;

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 40)
      $display("mismatch %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  task automatic apply_observed_key(input logic [31:0] raw_key);
    logic [31:0] k;
    int          hit;
    int          vacant;
    k = raw_key & KEY_MASK;
    hit = -1;
    vacant = -1;
    if (seen_count != CNT_MAX) seen_count++;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && table_count[i] != '0 && table_key[i] == k) hit = i;
    end
    if (hit >= 0) begin
      if (table_count[hit] != CNT_MAX) table_count[hit]++;
      return;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (table_count[i] == '0) vacant = i;
    end
    if (vacant >= 0) begin
      table_key[vacant] = k;
      table_count[vacant] = 1;
      return;
    end
    // Table full: drop the key, decrement every occupied slot
    for (int i = 0; i < SLOTS; i++) begin
      if (table_count[i] != '0) table_count[i]--;
    end
  endtask

  task automatic queue_slot_report();
    logic [47:0] prod;
    logic [31:0] floor_count;
    out_t        r;
    prod = 48'(heavy_frac) * 48'(seen_count);
    floor_count = prod[47:16];
    for (int i = 0; i < SLOTS; i++) begin
      r.slot_key = table_key[i];
      r.slot_count = table_count[i];
      r.heavy = (table_count[i] >= floor_count);
      r.last = (i == SLOTS - 1);
      pending_slots.push_back(r);
    end
  endtask

  // Compare each strobed slot against the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_strobe) begin
      if (pending_slots.size() == 0) begin
        report_mismatch("unexpected word key", out_word.slot_key, 32'h0);
      end else begin
        want = pending_slots.pop_front();
        if (out_word.slot_key !== want.slot_key)
          report_mismatch("slot_key", out_word.slot_key, want.slot_key);
        if (out_word.slot_count !== want.slot_count)
          report_mismatch("slot_count", out_word.slot_count, want.slot_count);
        if (out_word.heavy !== want.heavy)
          report_mismatch("heavy", 32'(out_word.heavy), 32'(want.heavy));
        if (out_word.last !== want.last)
          report_mismatch("last", 32'(out_word.last), 32'(want.last));
      end
    end
  end

  // Send one word; start stays high on return so back-to-back words need no gap
  task automatic send_word(input logic mode, input logic [31:0] key);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    in_word.mode <= mode;
    in_word.key <= key;
    do @(posedge clk); while (busy);
    if (mode == MODE_REPORT) queue_slot_report();
    else apply_observed_key(key);
  endtask

  task automatic observe(input logic [31:0] key);
    send_word(MODE_OBSERVE, key);
  endtask

  task automatic request_report();
    send_word(MODE_REPORT, $urandom);
  endtask

  // Hold off until every expected slot has arrived and the row has settled
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_slots.size() != 0 || busy) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  task automatic set_fraction(input logic [FRAC_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    heavy_frac = v;
  endtask

  task automatic test_empty_report();
    idle_pct = 0;
    set_fraction('0);
    request_report();
    wait_drained();
  endtask

  task automatic test_slot_cases();
    idle_pct = 0;
    set_fraction('1);
    // Stale key 0 in empty slots must not match
    observe(32'h0000_0000);
    observe(32'h0000_0000);
    observe(32'hFFFF_FFFF);
    observe(32'hAAAA_AAAA);
    observe(32'h5555_5555);
    for (int i = 0; i < 11; i++) observe(32'h0000_0001 << (i * 3));
    request_report();
    // One slot is still empty: the new key takes it, nothing is decremented
    observe(32'h8000_0001);
    request_report();
    // Keys already held in the table count up in their own slots
    observe(32'hFFFF_FFFF);
    observe(32'hAAAA_AAAA);
    request_report();
    wait_drained();
  endtask

  task automatic test_key_stream(input int pct, input logic [FRAC_W-1:0] frac,
                                 input int count, input bit mid_pause);
    logic [31:0] hot [6];
    logic [31:0] warm [24];
    int          pick;
    set_fraction(frac);
    idle_pct = pct;
    foreach (hot[i]) hot[i] = $urandom;
    foreach (warm[i]) warm[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      if (mid_pause && n == count / 2) wait_drained();
      pick = $urandom_range(99);
      if (pick < 8) request_report();
      else if (pick < 60) observe(hot[$urandom_range(5)]);
      else if (pick < 85) observe(warm[$urandom_range(23)]);
      else observe($urandom);
    end
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_word <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    for (int i = 0; i < SLOTS; i++) begin
      table_key[i] = '0;
      table_count[i] = '0;
    end
    seen_count = '0;
    heavy_frac = '0;
    error_count = 0;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_report();
    test_slot_cases();
    test_key_stream(0, 16'(($urandom_range(8191))), 115, 1'b1);
    test_key_stream(72, '1, 115, 1'b0);
    test_key_stream(16, 16'($urandom_range(4095)), 115, 1'b0);
    test_key_stream(0, 16'($urandom), 115, 1'b0);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
